// File: hdl/i8lrq_pkg.sv
// Shared types and constants for the int8 linear requantize core.
package i8lrq_pkg;

    // Field widths
    localparam int unsigned ACT_W   = 8;
    localparam int unsigned WGT_W   = 8;
    localparam int unsigned SUM_W   = 32;
    localparam int unsigned WZO_W   = 9;
    localparam int unsigned OUT_W   = 8;
    localparam int unsigned MULT_W  = 31;
    localparam int unsigned SHIFT_W = 6;
    localparam int unsigned PROD_W  = 63;  // bits 62..0 of the 64-bit requant product
    localparam int unsigned ADDR_W  = 5;

    // Round bias added to the Q31 product
    localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(64'd1 << 30);
    localparam int unsigned       Q_SHIFT    = 31;

    // Register indexes
    localparam logic [2:0] REG_WZO   = 3'd0;
    localparam logic [2:0] REG_ROFF  = 3'd1;
    localparam logic [2:0] REG_MULT  = 3'd2;
    localparam logic [2:0] REG_SHIFT = 3'd3;
    localparam logic [2:0] REG_CLO   = 3'd4;
    localparam logic [2:0] REG_CHI   = 3'd5;

    // Reset values
    localparam logic [MULT_W-1:0] MULT_RESET = 31'd1073741824;
    localparam logic [OUT_W-1:0]  CLO_RESET  = 8'h80;
    localparam logic [OUT_W-1:0]  CHI_RESET  = 8'h7f;

    // Controller states
    typedef enum logic [3:0] {
        ST_ACCUM,
        ST_ZERO_MUL,
        ST_SUM,
        ST_SHIFT_L,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ROUND,
        ST_SHIFT_R,
        ST_EMIT
    } st_t;

    // Datapath step enables
    typedef struct packed {
        logic mac;
        logic zero_mul;
        logic sum;
        logic shift_l;
        logic mul_lo;
        logic mul_hi;
        logic round;
        logic shift_r;
        logic emit;
    } dp_cmd_t;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic signed [WZO_W-1:0]   wzo;
        logic signed [OUT_W-1:0]   roff;
        logic        [MULT_W-1:0]  mult;
        logic signed [SHIFT_W-1:0] shift;
        logic signed [OUT_W-1:0]   clo;
        logic signed [OUT_W-1:0]   chi;
    } cfg_t;

endpackage

// File: hdl/i8lrq_ctrl.sv
// Sequencing state machine and output valid flag.
module i8lrq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_last,
    input  logic                m_ready,
    output logic                s_ready,
    output logic                m_valid,
    output i8lrq_pkg::dp_cmd_t  cmd
);
    import i8lrq_pkg::*;

    st_t  state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic accept;

    assign s_ready = (state_reg == ST_ACCUM);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    // State and valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACCUM;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and step enables
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = (m_valid_reg && !m_ready);
        case (state_reg)
            ST_ACCUM: begin
                cmd.mac = accept;
                if (accept && s_last) state_next = ST_ZERO_MUL;
            end
            ST_ZERO_MUL: begin
                cmd.zero_mul = 1'b1;
                state_next   = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_SHIFT_L;
            end
            ST_SHIFT_L: begin
                cmd.shift_l = 1'b1;
                state_next  = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                cmd.mul_hi = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round  = 1'b1;
                state_next = ST_SHIFT_R;
            end
            ST_SHIFT_R: begin
                cmd.shift_r = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT: begin
                // wait until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.emit     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_ACCUM;
                end
            end
            default: state_next = ST_ACCUM;
        endcase
    end

endmodule

// File: hdl/i8lrq_dp.sv
// Accumulators, requantization steps and output register.
module i8lrq_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  i8lrq_pkg::dp_cmd_t                    cmd,
    input  i8lrq_pkg::cfg_t                       cfg,
    input  logic signed [i8lrq_pkg::ACT_W-1:0]    s_activation,
    input  logic signed [i8lrq_pkg::WGT_W-1:0]    s_weight,
    input  logic signed [i8lrq_pkg::SUM_W-1:0]    s_column_bias,
    output logic signed [i8lrq_pkg::OUT_W-1:0]    m_result
);
    import i8lrq_pkg::*;

    logic [SUM_W-1:0]         psum_reg, psum_next;
    logic [SUM_W-1:0]         asum_reg, asum_next;
    logic [SUM_W-1:0]         bias_reg;
    logic [SUM_W-1:0]         zp_reg;
    logic [SUM_W-1:0]         acc_reg;
    logic [PROD_W-1:0]        v_reg;
    logic [PROD_W-1:0]        plo_reg;
    logic [MULT_W-1:0]        phi_reg;
    logic [SUM_W-1:0]         r_reg;
    logic [SUM_W-1:0]         q_reg;
    logic signed [OUT_W-1:0]  out_reg;

    logic signed [ACT_W+WGT_W-1:0]   mac_prod;
    logic signed [SUM_W+WZO_W-1:0]   zp_full;
    logic [63:0]                     v_wide;
    logic [2*MULT_W-1:0]             phi_full;
    logic [PROD_W-1:0]               p_sum;
    logic [SHIFT_W-1:0]              right;
    logic signed [SUM_W:0]           rx, down;
    logic [SUM_W:0]                  mask, rem, thr;
    logic signed [SUM_W:0]           y, y_lo;
    logic signed [OUT_W-1:0]         clamped;

    // Multiply-accumulate of one transaction
    assign mac_prod  = s_activation * s_weight;
    assign psum_next = psum_reg + SUM_W'(mac_prod);
    assign asum_next = asum_reg + SUM_W'(s_activation);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            psum_reg <= '0;
            asum_reg <= '0;
        end else if (cmd.mac) begin
            psum_reg <= psum_next;
            asum_reg <= asum_next;
        end else if (cmd.sum) begin
            // sums are consumed here; clear for the next dot product
            psum_reg <= '0;
            asum_reg <= '0;
        end
    end

    // Activation sum times weight offset, wrapping to 32 bits
    assign zp_full = $signed(asum_reg) * cfg.wzo;

    // Left shift for a positive shift amount
    always_comb begin
        v_wide = {{(64-SUM_W){acc_reg[SUM_W-1]}}, acc_reg};
        if (!cfg.shift[SHIFT_W-1] && (cfg.shift != '0)) begin
            v_wide = v_wide << cfg.shift[SHIFT_W-2:0];
        end
    end

    // High partial product, only its low bits reach the kept window
    assign phi_full = v_reg[PROD_W-1:SUM_W] * cfg.mult;
    assign p_sum    = plo_reg + {phi_reg, {SUM_W{1'b0}}} + ROUND_BIAS;

    // Rounding right shift, ties away from zero
    always_comb begin
        right = -cfg.shift;
        rx    = {r_reg[SUM_W-1], r_reg};
        down  = rx >>> right;
        mask  = ((SUM_W+1)'(1) << right) - (SUM_W+1)'(1);
        rem   = rx & mask;
        thr   = (mask >> 1) + (SUM_W+1)'(r_reg[SUM_W-1]);
        if (rem > thr) begin
            down = down + (SUM_W+1)'(1);
        end
    end

    // Offset add and clamp, low bound first
    always_comb begin
        y = $signed({q_reg[SUM_W-1], q_reg}) + (SUM_W+1)'(cfg.roff);
        y_lo = (y < (SUM_W+1)'(cfg.clo)) ? (SUM_W+1)'(cfg.clo) : y;
        if (y_lo > (SUM_W+1)'(cfg.chi)) begin
            clamped = cfg.chi;
        end else begin
            clamped = y_lo[OUT_W-1:0];
        end
    end

    // Requantization pipeline registers
    always_ff @(posedge aclk) begin
        if (cmd.mac)      bias_reg <= s_column_bias;
        if (cmd.zero_mul) zp_reg   <= zp_full[SUM_W-1:0];
        if (cmd.sum)      acc_reg  <= psum_reg + zp_reg + bias_reg;
        if (cmd.shift_l)  v_reg    <= v_wide[PROD_W-1:0];
        if (cmd.mul_lo)   plo_reg  <= v_reg[SUM_W-1:0] * cfg.mult;
        if (cmd.mul_hi)   phi_reg  <= phi_full[MULT_W-1:0];
        if (cmd.round)    r_reg    <= p_sum[PROD_W-1:Q_SHIFT];
        if (cmd.shift_r)  q_reg    <= cfg.shift[SHIFT_W-1] ? down[SUM_W-1:0] : r_reg;
        if (cmd.emit)     out_reg  <= clamped;
    end

    assign m_result = out_reg;

endmodule

// File: hdl/int8_linear_requantize_core.sv
// Top level: register file, controller and datapath of the int8 requantize core.
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    activation, weight, column_bias, last
//  m_        out        m_valid/m_ready    result
//  apb       in         psel/penable       pwrite, paddr, pwdata, prdata
//
// A transaction without last is taken every cycle; the multiply-accumulate
// finishes in that cycle. A last transaction starts the requantize sequence
// (weight offset multiply, sum, shift, two Q31 partial products,
// round, right shift, clamp); s_ready is low through it until the result
// is emitted. The result waits in an output register while new
// transactions are accumulated. Reset is synchronous, active low.
module int8_linear_requantize_core (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [i8lrq_pkg::ACT_W-1:0]     s_activation,
    input  logic signed [i8lrq_pkg::WGT_W-1:0]     s_weight,
    input  logic signed [i8lrq_pkg::SUM_W-1:0]     s_column_bias,
    input  logic                                   s_last,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [i8lrq_pkg::OUT_W-1:0]     m_result,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [i8lrq_pkg::ADDR_W-1:0]           paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    import i8lrq_pkg::*;

    cfg_t    cfg_reg;
    dp_cmd_t cmd;
    logic    wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[ADDR_W-1:2];

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wzo   <= '0;
            cfg_reg.roff  <= '0;
            cfg_reg.mult  <= MULT_RESET;
            cfg_reg.shift <= '0;
            cfg_reg.clo   <= CLO_RESET;
            cfg_reg.chi   <= CHI_RESET;
        end else if (wr_en) begin
            case (idx)
                REG_WZO:   cfg_reg.wzo   <= pwdata[WZO_W-1:0];
                REG_ROFF:  cfg_reg.roff  <= pwdata[OUT_W-1:0];
                REG_MULT:  cfg_reg.mult  <= pwdata[MULT_W-1:0];
                REG_SHIFT: cfg_reg.shift <= pwdata[SHIFT_W-1:0];
                REG_CLO:   cfg_reg.clo   <= pwdata[OUT_W-1:0];
                REG_CHI:   cfg_reg.chi   <= pwdata[OUT_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (idx)
            REG_WZO:   prdata = {{(32-WZO_W){cfg_reg.wzo[WZO_W-1]}}, cfg_reg.wzo};
            REG_ROFF:  prdata = {{(32-OUT_W){cfg_reg.roff[OUT_W-1]}}, cfg_reg.roff};
            REG_MULT:  prdata = {1'b0, cfg_reg.mult};
            REG_SHIFT: prdata = {{(32-SHIFT_W){cfg_reg.shift[SHIFT_W-1]}}, cfg_reg.shift};
            REG_CLO:   prdata = {{(32-OUT_W){cfg_reg.clo[OUT_W-1]}}, cfg_reg.clo};
            REG_CHI:   prdata = {{(32-OUT_W){cfg_reg.chi[OUT_W-1]}}, cfg_reg.chi};
            default:   prdata = '0;
        endcase
    end

    i8lrq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_last),
        .m_ready (m_ready),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .cmd     (cmd)
    );

    i8lrq_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .cfg           (cfg_reg),
        .s_activation  (s_activation),
        .s_weight      (s_weight),
        .s_column_bias (s_column_bias),
        .m_result      (m_result)
    );

endmodule

// File: hdl/i8lrq_chk.sv
// Port-level checks for the int8 requantize core, bound to the top level.
module i8lrq_chk (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                s_last,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [i8lrq_pkg::OUT_W-1:0]  m_result
);
    import i8lrq_pkg::*;

    // A pending result holds until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result))
        else $error("result changed while stalled");

    // A last transaction keeps the input closed during requantization
    a_busy_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last |=> !s_ready ##1 !s_ready ##1 !s_ready)
        else $error("input reopened too early after last transaction");

    // The input reopens only together with a fresh result
    a_reopen_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(s_ready) && $past(aresetn) |-> m_valid)
        else $error("input reopened without a result");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind int8_linear_requantize_core i8lrq_chk u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .s_last   (s_last),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_result (m_result)
);
